// File: rtl/pn3d_pkg.sv
package pn3d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int TBL_DEPTH     = 256;
    localparam int TBL_AW        = 8;
    localparam int HASH_W        = 8;
    localparam int NCORNER       = 8;
    localparam int OUT_W         = 18;
    localparam int OUT_MAX       = 131071;
    localparam int OUT_MIN       = -131072;
    localparam int SAT_W         = 48;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

    localparam logic signed [1:0] GRAD_POS  = 2'sb01;
    localparam logic signed [1:0] GRAD_NEG  = 2'sb11;
    localparam logic signed [1:0] GRAD_ZERO = 2'sb00;

    typedef struct packed {
        logic                  we;
        logic [TBL_AW-1:0]     addr;
        logic [HASH_W-1:0]     data;
    } t_tbl_wr;

    typedef struct packed {
        logic signed [1:0] gx;
        logic signed [1:0] gy;
        logic signed [1:0] gz;
    } t_grad;

    function automatic t_grad grad_of(input logic [3:0] h);
        t_grad g;
        unique case (h)
            4'd0:  g = '{GRAD_POS,  GRAD_POS,  GRAD_ZERO};
            4'd1:  g = '{GRAD_NEG,  GRAD_POS,  GRAD_ZERO};
            4'd2:  g = '{GRAD_POS,  GRAD_NEG,  GRAD_ZERO};
            4'd3:  g = '{GRAD_NEG,  GRAD_NEG,  GRAD_ZERO};
            4'd4:  g = '{GRAD_POS,  GRAD_ZERO, GRAD_POS};
            4'd5:  g = '{GRAD_NEG,  GRAD_ZERO, GRAD_POS};
            4'd6:  g = '{GRAD_POS,  GRAD_ZERO, GRAD_NEG};
            4'd7:  g = '{GRAD_NEG,  GRAD_ZERO, GRAD_NEG};
            4'd8:  g = '{GRAD_ZERO, GRAD_POS,  GRAD_POS};
            4'd9:  g = '{GRAD_ZERO, GRAD_NEG,  GRAD_POS};
            4'd10: g = '{GRAD_ZERO, GRAD_POS,  GRAD_NEG};
            4'd11: g = '{GRAD_ZERO, GRAD_NEG,  GRAD_NEG};
            4'd12: g = '{GRAD_POS,  GRAD_POS,  GRAD_ZERO};
            4'd13: g = '{GRAD_ZERO, GRAD_NEG,  GRAD_POS};
            4'd14: g = '{GRAD_NEG,  GRAD_POS,  GRAD_ZERO};
            4'd15: g = '{GRAD_ZERO, GRAD_NEG,  GRAD_NEG};
            default: g = '{GRAD_ZERO, GRAD_ZERO, GRAD_ZERO};
        endcase
        return g;
    endfunction

endpackage

// File: rtl/pn3d_ram.sv
module pn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/pn3d_fade.sv
module pn3d_fade
    import pn3d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int AW = FRAC_BITS + 5
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_t,
    output logic signed [AW-1:0] o_fade
);

    localparam logic signed [AW-1:0]   K15 = AW'(15 * (2 ** FRAC_BITS));
    localparam logic signed [AW-1:0]   K10 = AW'(10 * (2 ** FRAC_BITS));
    localparam logic signed [2*AW-1:0] PH  = (2*AW)'(2 ** (FRAC_BITS - 1));

    logic signed [AW-1:0]   w_te;
    logic signed [AW-1:0]   w_a;
    logic signed [2*AW-1:0] w_pa;
    logic signed [2*AW-1:0] w_pt;
    logic signed [2*AW-1:0] w_p3;
    logic signed [2*AW-1:0] w_pf;

    logic signed [AW-1:0] r_t;
    logic signed [AW-1:0] r_b;
    logic signed [AW-1:0] r_t2;
    logic signed [AW-1:0] r_b2;
    logic signed [AW-1:0] r_t3;
    logic signed [AW-1:0] r_fade;

    assign w_te = AW'($signed({1'b0, i_t}));
    assign w_a  = (w_te <<< 2) + (w_te <<< 1) - K15;
    assign w_pa = w_te * w_a;
    assign w_pt = w_te * w_te;
    assign w_p3 = r_t2 * r_t;
    assign w_pf = r_t3 * r_b2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= w_te;
            r_b    <= AW'((w_pa + PH) >>> FRAC_BITS) + K10;
            r_t2   <= AW'((w_pt + PH) >>> FRAC_BITS);
            r_b2   <= r_b;
            r_t3   <= AW'((w_p3 + PH) >>> FRAC_BITS);
            r_fade <= AW'((w_pf + PH) >>> FRAC_BITS);
        end
    end

    assign o_fade = r_fade;

endmodule

// File: rtl/pn3d_lerp.sv
module pn3d_lerp
    import pn3d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int VW = FRAC_BITS + 4,
    parameter int FW = FRAC_BITS + 5
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [FW-1:0] i_w,
    input  logic signed [VW-1:0] i_s,
    input  logic signed [VW-1:0] i_e,
    output logic signed [VW-1:0] o_r
);

    localparam int PW = FW + VW + 1;
    localparam logic signed [PW-1:0] PH = PW'(2 ** (FRAC_BITS - 1));

    logic signed [VW:0]   w_d;
    logic signed [PW-1:0] w_p;
    logic signed [VW-1:0] r_r;

    assign w_d = (VW + 1)'(i_e) - (VW + 1)'(i_s);
    assign w_p = PW'(i_w) * PW'(w_d);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= i_s + VW'((w_p + PH) >>> FRAC_BITS);
        end
    end

    assign o_r = r_r;

endmodule

// File: rtl/pn3d_hash.sv
module pn3d_hash
    import pn3d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic              i_cmd,
    input  logic [TBL_AW-1:0] i_idx,
    input  logic [HASH_W-1:0] i_val,
    input  logic [HASH_W-1:0] i_cx,
    input  logic [HASH_W-1:0] i_cy,
    input  logic [HASH_W-1:0] i_cz,
    input  t_tbl_wr           i_clr,
    output logic [HASH_W-1:0] o_hash [NCORNER]
);

    logic              r2_vld;
    logic              r2_cmd;
    logic [TBL_AW-1:0] r2_idx;
    logic [HASH_W-1:0] r2_val;
    logic [HASH_W-1:0] r2_cy;
    logic [HASH_W-1:0] r2_cz;
    logic              r3_vld;
    logic              r3_cmd;
    logic [TBL_AW-1:0] r3_idx;
    logic [HASH_W-1:0] r3_val;
    logic [HASH_W-1:0] r3_cz;

    logic [HASH_W-1:0] w_i;
    logic [HASH_W-1:0] w_j;
    logic [HASH_W-1:0] w_k;
    logic [HASH_W-1:0] w_l;
    logic [HASH_W-1:0] w_m;
    logic [HASH_W-1:0] w_n;
    logic [HASH_W-1:0] w_lo [4];
    logic [HASH_W-1:0] w_hi [4];
    logic [HASH_W-1:0] w_base [4];

    t_tbl_wr wr_a;
    t_tbl_wr wr_b;
    t_tbl_wr wr_c;

    always_comb begin
        wr_a = i_clr;
        wr_b = i_clr;
        wr_c = i_clr;
        if (!i_clr.we) begin
            wr_a = '{i_en && i_vld && (i_cmd == CMD_WRITE), i_idx, i_val};
            wr_b = '{i_en && r2_vld && (r2_cmd == CMD_WRITE), r2_idx, r2_val};
            wr_c = '{i_en && r3_vld && (r3_cmd == CMD_WRITE), r3_idx, r3_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= i_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cmd <= i_cmd;
            r2_idx <= i_idx;
            r2_val <= i_val;
            r2_cy  <= i_cy;
            r2_cz  <= i_cz;
            r3_cmd <= r2_cmd;
            r3_idx <= r2_idx;
            r3_val <= r2_val;
            r3_cz  <= r2_cz;
        end
    end

    pn3d_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_ram_a (
        .i_clk     (i_clk),
        .i_we      (wr_a.we),
        .i_waddr   (wr_a.addr),
        .i_wdata   (wr_a.data),
        .i_re      (i_en),
        .i_raddr_a (i_cx),
        .i_raddr_b (HASH_W'(i_cx + 1'b1)),
        .o_rdata_a (w_i),
        .o_rdata_b (w_j)
    );

    pn3d_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_ram_b0 (
        .i_clk     (i_clk),
        .i_we      (wr_b.we),
        .i_waddr   (wr_b.addr),
        .i_wdata   (wr_b.data),
        .i_re      (i_en),
        .i_raddr_a (HASH_W'(w_i + r2_cy)),
        .i_raddr_b (HASH_W'(w_i + r2_cy + 1'b1)),
        .o_rdata_a (w_k),
        .o_rdata_b (w_l)
    );

    pn3d_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_ram_b1 (
        .i_clk     (i_clk),
        .i_we      (wr_b.we),
        .i_waddr   (wr_b.addr),
        .i_wdata   (wr_b.data),
        .i_re      (i_en),
        .i_raddr_a (HASH_W'(w_j + r2_cy)),
        .i_raddr_b (HASH_W'(w_j + r2_cy + 1'b1)),
        .o_rdata_a (w_m),
        .o_rdata_b (w_n)
    );

    assign w_base[0] = w_k;
    assign w_base[1] = w_m;
    assign w_base[2] = w_l;
    assign w_base[3] = w_n;

    for (genvar g = 0; g < 4; g++) begin : g_ram_c
        pn3d_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_ram_c (
            .i_clk     (i_clk),
            .i_we      (wr_c.we),
            .i_waddr   (wr_c.addr),
            .i_wdata   (wr_c.data),
            .i_re      (i_en),
            .i_raddr_a (HASH_W'(w_base[g] + r3_cz)),
            .i_raddr_b (HASH_W'(w_base[g] + r3_cz + 1'b1)),
            .o_rdata_a (w_lo[g]),
            .o_rdata_b (w_hi[g])
        );
        assign o_hash[g]     = w_lo[g];
        assign o_hash[g + 4] = w_hi[g];
    end

endmodule

// File: rtl/perlin_noise_3d_core.sv
// 3D gradient noise, one sample per clock while nothing stalls.
// Input channel (i_valid / o_stall) carries one item per accepted edge:
// i_command selects a table write (i_table_index, i_table_value) or a noise
// sample at (i_coord_x, i_coord_y, i_coord_z), signed Q16.16 at the default
// FRAC_BITS. Only samples give a result; table writes are silent.
// Output channel (o_valid / i_stall) carries o_noise_value, signed Q2.16,
// rounded and saturated. o_valid is the sample flag of the last pipeline
// register. Throughput is one item per cycle while nothing stalls, set by
// the eight-stage pipeline and the seven copies of the permutation table,
// each read on two ports, the copies of one hash level sharing a stage.
// A table write reaches each copy as it passes that copy's stage, so items
// in flight before it still see the old entry and items after see the new.
// The origin registers sit on the APB port at 0x0, 0x4, 0x8.
// After reset the block loads the identity table into every entry of
// all copies; o_stall is high during that pass. While the output is stalled
// the whole pipeline holds and o_stall is high; nothing is lost or repeated.
module perlin_noise_3d_core
    import pn3d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic [TBL_AW-1:0]        i_table_index,
    input  logic [HASH_W-1:0]        i_table_value,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [OUT_W-1:0]  o_noise_value,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int DW = FRAC_BITS + 3;
    localparam int LW = FRAC_BITS + 4;
    localparam int FW = FRAC_BITS + 5;
    localparam logic signed [DW-1:0] ONE_Q = DW'(2 ** FRAC_BITS);

    logic [COORD_W-1:0] r_origin_x;
    logic [COORD_W-1:0] r_origin_y;
    logic [COORD_W-1:0] r_origin_z;
    logic               r_clr_busy;
    logic [TBL_AW-1:0]  r_clr_cnt;

    logic r1_vld;
    logic r1_cmd;
    logic r2_smp;
    logic r3_smp;
    logic r4_smp;
    logic r5_smp;
    logic r6_smp;
    logic r7_smp;
    logic r8_smp;

    logic [TBL_AW-1:0]    r1_idx;
    logic [HASH_W-1:0]    r1_val;
    logic [HASH_W-1:0]    r1_cx;
    logic [HASH_W-1:0]    r1_cy;
    logic [HASH_W-1:0]    r1_cz;
    logic [FRAC_BITS-1:0] r1_fx;
    logic [FRAC_BITS-1:0] r1_fy;
    logic [FRAC_BITS-1:0] r1_fz;
    logic [FRAC_BITS-1:0] r2_fx;
    logic [FRAC_BITS-1:0] r2_fy;
    logic [FRAC_BITS-1:0] r2_fz;
    logic [FRAC_BITS-1:0] r3_fx;
    logic [FRAC_BITS-1:0] r3_fy;
    logic [FRAC_BITS-1:0] r3_fz;
    logic [FRAC_BITS-1:0] r4_fx;
    logic [FRAC_BITS-1:0] r4_fy;
    logic [FRAC_BITS-1:0] r4_fz;
    logic signed [DW-1:0] r5_dot [NCORNER];
    logic signed [FW-1:0] r5_wx;
    logic signed [FW-1:0] r5_wy;
    logic signed [FW-1:0] r5_wz;
    logic signed [FW-1:0] r6_wy;
    logic signed [FW-1:0] r6_wz;
    logic signed [FW-1:0] r7_wz;

    logic                 w_en;
    logic [COORD_W-1:0]   w_sx;
    logic [COORD_W-1:0]   w_sy;
    logic [COORD_W-1:0]   w_sz;
    t_tbl_wr              w_clr;
    logic [HASH_W-1:0]    w_hash [NCORNER];
    logic signed [FW-1:0] w_fade_x;
    logic signed [FW-1:0] w_fade_y;
    logic signed [FW-1:0] w_fade_z;
    logic signed [DW-1:0] w_dot [NCORNER];
    logic signed [LW-1:0] w_ax [4];
    logic signed [LW-1:0] w_ay [2];
    logic signed [LW-1:0] w_v;
    logic signed [SAT_W-1:0] w_vx;

    function automatic logic signed [DW-1:0] gsel(input logic signed [1:0] g,
                                                  input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        unique case (g)
            GRAD_POS: r = v;
            GRAD_NEG: r = -v;
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign w_en    = !(r8_smp && i_stall);
    assign o_stall = r_clr_busy || !w_en;
    assign o_valid = r8_smp;
    assign pready  = 1'b1;

    assign w_sx = i_coord_x + r_origin_x;
    assign w_sy = i_coord_y + r_origin_y;
    assign w_sz = i_coord_z + r_origin_z;

    assign w_clr = '{r_clr_busy, r_clr_cnt, r_clr_cnt};

    always_comb begin
        unique case (paddr[3:2])
            REG_ORIGIN_X: prdata = r_origin_x;
            REG_ORIGIN_Y: prdata = r_origin_y;
            REG_ORIGIN_Z: prdata = r_origin_z;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_origin_z <= '0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r1_vld     <= 1'b0;
            r2_smp     <= 1'b0;
            r3_smp     <= 1'b0;
            r4_smp     <= 1'b0;
            r5_smp     <= 1'b0;
            r6_smp     <= 1'b0;
            r7_smp     <= 1'b0;
            r8_smp     <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_ORIGIN_X: r_origin_x <= pwdata;
                    REG_ORIGIN_Y: r_origin_y <= pwdata;
                    REG_ORIGIN_Z: r_origin_z <= pwdata;
                    default: ;
                endcase
            end
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == TBL_AW'(TBL_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_en) begin
                r1_vld <= i_valid && !r_clr_busy;
                r2_smp <= r1_vld && (r1_cmd == CMD_SAMPLE);
                r3_smp <= r2_smp;
                r4_smp <= r3_smp;
                r5_smp <= r4_smp;
                r6_smp <= r5_smp;
                r7_smp <= r6_smp;
                r8_smp <= r7_smp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd <= i_command;
            r1_idx <= i_table_index;
            r1_val <= i_table_value;
            r1_cx  <= w_sx[FRAC_BITS +: HASH_W];
            r1_cy  <= w_sy[FRAC_BITS +: HASH_W];
            r1_cz  <= w_sz[FRAC_BITS +: HASH_W];
            r1_fx  <= w_sx[FRAC_BITS-1:0];
            r1_fy  <= w_sy[FRAC_BITS-1:0];
            r1_fz  <= w_sz[FRAC_BITS-1:0];
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_fz  <= r1_fz;
            r3_fx  <= r2_fx;
            r3_fy  <= r2_fy;
            r3_fz  <= r2_fz;
            r4_fx  <= r3_fx;
            r4_fy  <= r3_fy;
            r4_fz  <= r3_fz;
            r5_dot <= w_dot;
            r5_wx  <= w_fade_x;
            r5_wy  <= w_fade_y;
            r5_wz  <= w_fade_z;
            r6_wy  <= r5_wy;
            r6_wz  <= r5_wz;
            r7_wz  <= r6_wz;
        end
    end

    pn3d_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r1_vld),
        .i_cmd   (r1_cmd),
        .i_idx   (r1_idx),
        .i_val   (r1_val),
        .i_cx    (r1_cx),
        .i_cy    (r1_cy),
        .i_cz    (r1_cz),
        .i_clr   (w_clr),
        .o_hash  (w_hash)
    );

    pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .i_clk (i_clk), .i_en (w_en), .i_t (r1_fx), .o_fade (w_fade_x)
    );
    pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .i_clk (i_clk), .i_en (w_en), .i_t (r1_fy), .o_fade (w_fade_y)
    );
    pn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
        .i_clk (i_clk), .i_en (w_en), .i_t (r1_fz), .o_fade (w_fade_z)
    );

    always_comb begin
        logic signed [DW-1:0] x0;
        logic signed [DW-1:0] y0;
        logic signed [DW-1:0] z0;
        t_grad                g;
        x0 = DW'($signed({1'b0, r4_fx}));
        y0 = DW'($signed({1'b0, r4_fy}));
        z0 = DW'($signed({1'b0, r4_fz}));
        for (int c = 0; c < NCORNER; c++) begin
            g = grad_of(w_hash[c][3:0]);
            w_dot[c] = gsel(g.gx, c[0] ? x0 - ONE_Q : x0)
                     + gsel(g.gy, c[1] ? y0 - ONE_Q : y0)
                     + gsel(g.gz, c[2] ? z0 - ONE_Q : z0);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lerp_x
        pn3d_lerp #(.FRAC_BITS(FRAC_BITS), .VW(LW), .FW(FW)) u_lerp (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_w   (r5_wx),
            .i_s   (LW'(r5_dot[2*g])),
            .i_e   (LW'(r5_dot[2*g+1])),
            .o_r   (w_ax[g])
        );
    end

    for (genvar g = 0; g < 2; g++) begin : g_lerp_y
        pn3d_lerp #(.FRAC_BITS(FRAC_BITS), .VW(LW), .FW(FW)) u_lerp (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_w   (r6_wy),
            .i_s   (w_ax[2*g]),
            .i_e   (w_ax[2*g+1]),
            .o_r   (w_ay[g])
        );
    end

    pn3d_lerp #(.FRAC_BITS(FRAC_BITS), .VW(LW), .FW(FW)) u_lerp_z (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_w   (r7_wz),
        .i_s   (w_ay[0]),
        .i_e   (w_ay[1]),
        .o_r   (w_v)
    );

    assign w_vx = SAT_W'(w_v);

    always_comb begin
        priority if (w_vx > SAT_W'(OUT_MAX)) begin
            o_noise_value = OUT_W'(OUT_MAX);
        end else if (w_vx < SAT_W'(OUT_MIN)) begin
            o_noise_value = OUT_W'(OUT_MIN);
        end else begin
            o_noise_value = OUT_W'(w_vx);
        end
    end

endmodule

// File: rtl/pn3d_chk.sv
module pn3d_chk
    import pn3d_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [OUT_W-1:0]   o_noise_value,
    input logic                      psel,
    input logic                      penable,
    input logic                      pwrite,
    input logic [APB_AW-1:0]         paddr,
    input logic [APB_DW-1:0]         pwdata,
    input logic [APB_DW-1:0]         prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_value))
        else $error("stalled output item changed");

    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_stall && !o_valid)
        else $error("table load pass not running after reset");

    a_origin_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr[3:2] == REG_ORIGIN_X)
            ##1 (paddr[3:2] == REG_ORIGIN_X)
        |-> prdata == $past(pwdata))
        else $error("origin_x readback mismatch");

    a_input_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_stall && !$past(o_stall) |-> o_valid && i_stall)
        else $error("input stalled without a stalled output item");

endmodule

bind perlin_noise_3d_core pn3d_chk u_chk (.*);
